/* hw/rtl/q2y_pkg.sv */
// q2y_pkg: widths, payload structs and the CORDIC arctangent table for quaternion_to_yaw.
// No dependencies; every other file imports it.
package q2y_pkg;

    localparam int Q_W          = 16;          // quaternion component width
    localparam int PROD_W       = 32;          // 16x16 signed product
    localparam int TERM_W       = 34;          // sine/cosine terms, 1.0 = 2^30
    localparam int CW           = 37;          // CORDIC x/y datapath, headroom for gain
    localparam int ANG_W        = 34;          // angle accumulator, pi = 2^31
    localparam int OUT_W        = 17;          // yaw output, pi = 2^15
    localparam int RND_SH       = 16;          // accumulator to output scale
    localparam int RND_W        = ANG_W + 1 - RND_SH;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int NSTEP        = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(64'sd1073741824);
    localparam logic signed [TERM_W-1:0] TERM_ONE   = TERM_W'(64'sd1073741824);
    localparam logic signed [OUT_W-1:0]  YAW_PI     = OUT_W'(32768);

    typedef struct packed {
        logic signed [TERM_W-1:0] s;
        logic signed [TERM_W-1:0] c;
    } t_terms;

    typedef struct packed {
        logic                     vld;
        logic                     spec;     // sine term zero
        logic                     spec_neg; // cosine term negative
        logic signed [CW-1:0]     x;
        logic signed [CW-1:0]     y;
        logic signed [ANG_W-1:0]  z;
    } t_stage;

    // atan(2^-i)/pi * 2^31, rounded
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return {{(ANG_W-32){1'b0}}, v};
    endfunction

endpackage

/* hw/rtl/q2y_front.sv */
// q2y_front: input side. Registers the four products, then the sine and cosine terms.
// Depends on q2y_pkg.
module q2y_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [q2y_pkg::Q_W-1:0] i_quat_w,
    input  logic signed [q2y_pkg::Q_W-1:0] i_quat_x,
    input  logic signed [q2y_pkg::Q_W-1:0] i_quat_y,
    input  logic signed [q2y_pkg::Q_W-1:0] i_quat_z,
    output logic                        o_valid,
    input  logic                        i_ready,
    output q2y_pkg::t_terms             o_terms
);
    import q2y_pkg::*;

    logic                     r_v1, r_v2;
    logic signed [PROD_W-1:0] r_wz, r_xy, r_yy, r_zz;
    t_terms                   r_terms, n_terms;
    logic                     rdy1, rdy2;
    logic signed [TERM_W-1:0] sum_s, sum_c;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;
    assign o_terms = r_terms;

    // S = 2(wz+xy), C = 1 - 2(yy+zz), exact
    always_comb begin
        sum_s     = TERM_W'(r_wz) + TERM_W'(r_xy);
        sum_c     = TERM_W'(r_yy) + TERM_W'(r_zz);
        n_terms.s = sum_s <<< 1;
        n_terms.c = TERM_ONE - (sum_c <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_wz <= i_quat_w * i_quat_z;
            r_xy <= i_quat_x * i_quat_y;
            r_yy <= i_quat_y * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
        end
        if (rdy2 && r_v1) r_terms <= n_terms;
    end

endmodule

/* hw/rtl/q2y_fifo.sv */
// q2y_fifo: short queue of sine/cosine term pairs between front and CORDIC back end.
// Depends on q2y_pkg.
module q2y_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  q2y_pkg::t_terms i_terms,
    output logic            o_valid,
    input  logic            i_ready,
    output q2y_pkg::t_terms o_terms
);
    import q2y_pkg::*;

    t_terms             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [FIFO_AW:0]   r_cnt;
    logic               push, pop;

    assign o_ready = r_cnt != (FIFO_AW+1)'(FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_terms = mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) mem[r_wr] <= i_terms;
    end

endmodule

/* hw/rtl/q2y_cordic.sv */
// q2y_cordic: back end. Quadrant pre-rotation, unrolled CORDIC vectoring stages,
// rounding and the output register. Depends on q2y_pkg.
module q2y_cordic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  q2y_pkg::t_terms               i_terms,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [q2y_pkg::OUT_W-1:0] o_yaw
);
    import q2y_pkg::*;

    t_stage                  r_stg [NSTEP+1];
    t_stage                  n_pre;
    logic                    adv;
    logic                    r_ovld;
    logic signed [OUT_W-1:0] r_yaw, n_yaw;
    logic signed [CW-1:0]    s_x, c_x;
    logic signed [ANG_W:0]   rnd_t;
    logic signed [RND_W-1:0] rnd_r;

    // whole pipeline moves whenever the output register can take a transaction
    assign adv     = !r_ovld || i_ready;
    assign o_ready = adv;
    assign o_valid = r_ovld;
    assign o_yaw   = r_yaw;

    // pre-rotation by +-pi/2 when the cosine term is negative
    always_comb begin
        s_x            = CW'(i_terms.s);
        c_x            = CW'(i_terms.c);
        n_pre.vld      = i_valid;
        n_pre.spec     = i_terms.s == '0;
        n_pre.spec_neg = i_terms.c[TERM_W-1];
        if (i_terms.c[TERM_W-1]) begin
            if (!i_terms.s[TERM_W-1]) begin
                n_pre.x = s_x;
                n_pre.y = -c_x;
                n_pre.z = ANG_HALF_PI;
            end else begin
                n_pre.x = -s_x;
                n_pre.y = c_x;
                n_pre.z = -ANG_HALF_PI;
            end
        end else begin
            n_pre.x = c_x;
            n_pre.y = s_x;
            n_pre.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_stg[0].vld <= 1'b0;
        else if (adv) r_stg[0] <= n_pre;
    end

    for (genvar k = 1; k <= NSTEP; k++) begin : g_iter
        localparam int SH = k - 1;
        t_stage p, n;
        logic   pos;
        always_comb begin
            p   = r_stg[k-1];
            n   = p;
            pos = !p.y[CW-1] && (p.y != '0);
            if (pos) begin
                n.x = p.x + (p.y >>> SH);
                n.y = p.y - (p.x >>> SH);
                n.z = p.z + atan_entry(5'(SH));
            end else begin
                n.x = p.x - (p.y >>> SH);
                n.y = p.y + (p.x >>> SH);
                n.z = p.z - atan_entry(5'(SH));
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_stg[k].vld <= 1'b0;
            else if (adv) r_stg[k] <= n;
        end
    end

    // round half up to pi = 2^15, clamp, then the zero-sine cases
    always_comb begin
        rnd_t = {r_stg[NSTEP].z[ANG_W-1], r_stg[NSTEP].z} + (ANG_W+1)'(32768);
        rnd_r = RND_W'(rnd_t >>> RND_SH);
        if (rnd_r > RND_W'(32768))
            n_yaw = YAW_PI;
        else if (rnd_r < -RND_W'(32768))
            n_yaw = -YAW_PI;
        else
            n_yaw = OUT_W'(rnd_r);
        if (r_stg[NSTEP].spec)
            n_yaw = r_stg[NSTEP].spec_neg ? YAW_PI : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (adv) r_ovld <= r_stg[NSTEP].vld;
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_stg[NSTEP].vld) r_yaw <= n_yaw;
    end

endmodule

/* hw/rtl/quaternion_to_yaw.sv */
// quaternion_to_yaw: top level, yaw angle of an orientation quaternion.
// Depends on q2y_pkg, q2y_front, q2y_fifo, q2y_cordic.
//
// One transaction in carries a quaternion (w, x, y, z) in signed Q1.15; one
// transaction out carries its yaw about z as a 17-bit binary angle, 32768 = +pi,
// range -32768..32768. The block takes one quaternion per clock and returns
// one result per clock in steady state when the receiver does not stall. From
// input acceptance to o_valid, the products register on the accepting edge,
// then come the sine/cosine terms, the queue, the pre-rotation stage, a
// register for each CORDIC iteration and the output register. Both terms zero
// gives 0; zero sine with negative cosine gives +pi. Unnormalised quaternions
// are taken as they are. The two-entry queue between the front and the CORDIC
// pipeline lets the input keep accepting while a result waits at the output,
// until the queue and the front registers are full.
module quaternion_to_yaw (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [q2y_pkg::Q_W-1:0]   i_quat_w,
    input  logic signed [q2y_pkg::Q_W-1:0]   i_quat_x,
    input  logic signed [q2y_pkg::Q_W-1:0]   i_quat_y,
    input  logic signed [q2y_pkg::Q_W-1:0]   i_quat_z,
    // result channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [q2y_pkg::OUT_W-1:0] o_yaw_angle
);
    import q2y_pkg::*;

    // front -> queue
    logic   f_valid, f_ready;
    t_terms f_terms;
    // queue -> back end
    logic   q_valid, q_ready;
    t_terms q_terms;

    q2y_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_quat_w (i_quat_w),
        .i_quat_x (i_quat_x),
        .i_quat_y (i_quat_y),
        .i_quat_z (i_quat_z),
        .o_valid  (f_valid),
        .i_ready  (f_ready),
        .o_terms  (f_terms)
    );

    q2y_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_terms (f_terms),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_terms (q_terms)
    );

    // back end: pre-rotation, CORDIC iterations, rounding, output register
    q2y_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_terms (q_terms),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_yaw   (o_yaw_angle)
    );

endmodule

/* tb/quaternion_to_yaw_test.sv */
// quaternion_to_yaw_test: self-checking bench for the quaternion-to-yaw block.
// Needs q2y_pkg and the quaternion_to_yaw RTL. A directed table runs first, then
// random quaternions under several handshake idling patterns, all checked in order.
`timescale 1ns / 100ps

module quaternion_to_yaw_test;

    import q2y_pkg::*;

    localparam longint HALF_PI_ANG = 64'sd1073741824;   // pi/2 in accumulator units
    localparam int     N_ROWS      = 21;
    localparam int     N_RANDOM    = 1400;
    localparam int     N_PHASES    = 4;

    // one directed row: quaternion, whether the yaw is typed in, and that yaw
    typedef struct packed {
        logic signed [Q_W-1:0]   w;
        logic signed [Q_W-1:0]   x;
        logic signed [Q_W-1:0]   y;
        logic signed [Q_W-1:0]   z;
        logic                    known;
        logic signed [OUT_W-1:0] yaw;
    } t_quat_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic signed [Q_W-1:0]   i_quat_w;
    logic signed [Q_W-1:0]   i_quat_x;
    logic signed [Q_W-1:0]   i_quat_y;
    logic signed [Q_W-1:0]   i_quat_z;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [OUT_W-1:0] o_yaw_angle;

    // idling odds, percent per cycle; changed per phase
    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;
    int          err_count;

    // yaw values still owed by the block, oldest first
    logic signed [OUT_W-1:0] yaw_due[$];

    // arctangent steps, atan(2^-i)/pi * 2^31
    longint angle_step [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    // directed cases: the typed-in yaws follow straight from the zero-sine rules
    t_quat_row quat_table [N_ROWS] = '{
        {16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1'b1, 17'sd0},     // identity
        {16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 17'sd0},     // null quaternion
        {16'h0000, 16'h0000, 16'h4000, 16'h4000, 1'b1, 17'sd0},     // both terms zero
        {16'h0000, 16'h0000, 16'hC000, 16'hC000, 1'b1, 17'sd0},     // both zero, negative
        {16'h0001, 16'hFFFF, 16'h4000, 16'h4000, 1'b1, 17'sd0},     // products cancel
        {16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 1'b1, 17'sd32768}, // zero sine, cos < 0
        {16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b1, 17'sd32768}, // zero sine, cos < 0
        {16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 1'b1, 17'sd32768}, // zero sine, cos < 0
        {16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 1'b1, 17'sd0},     // zero sine, cos > 0
        {16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 17'sd0},     // all most negative
        {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 17'sd0},     // all most positive
        {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0, 17'sd0},     // mixed extremes
        {16'h5A82, 16'h0000, 16'h0000, 16'h5A82, 1'b0, 17'sd0},     // about +pi/2
        {16'h5A82, 16'h0000, 16'h0000, 16'hA57E, 1'b0, 17'sd0},     // about -pi/2
        {16'h0100, 16'h0000, 16'h0000, 16'h7FFF, 1'b0, 17'sd0},     // just short of +pi
        {16'h0100, 16'h0000, 16'h0000, 16'h8001, 1'b0, 17'sd0},     // just short of -pi
        {16'h7FFF, 16'h0000, 16'h0000, 16'h0001, 1'b0, 17'sd0},     // tiny positive
        {16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 17'sd0},     // tiny negative
        {16'h8000, 16'h0000, 16'h0000, 16'h7FFF, 1'b0, 17'sd0},     // sine < 0, cos < 0
        {16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b0, 17'sd0},     // sine > 0, cos < 0
        {16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 1'b0, 17'sd0}      // sine < 0, cos < 0
    };

    quaternion_to_yaw dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_quat_w    (i_quat_w),
        .i_quat_x    (i_quat_x),
        .i_quat_y    (i_quat_y),
        .i_quat_z    (i_quat_z),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_yaw_angle (o_yaw_angle)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Yaw of a quaternion: exact sine/cosine terms (1.0 = 2^30), quadrant
    // pre-rotation when the cosine term is negative, then the vectoring
    // iterations with floor shifts. Accumulator pi = 2^31, rounded half up.
    function automatic logic signed [OUT_W-1:0] predict_yaw(
        input logic signed [Q_W-1:0] w,
        input logic signed [Q_W-1:0] x,
        input logic signed [Q_W-1:0] y,
        input logic signed [Q_W-1:0] z
    );
        longint sin_t, cos_t, vx, vy, ang, nx, rounded;
        sin_t = 2 * (longint'(w) * longint'(z) + longint'(x) * longint'(y));
        cos_t = HALF_PI_ANG - 2 * (longint'(y) * longint'(y) + longint'(z) * longint'(z));
        if (sin_t == 0) begin
            return (cos_t < 0) ? YAW_PI : '0;
        end
        if (cos_t < 0) begin
            // rotate by -/+ pi/2 into the right half plane
            if (sin_t > 0) begin
                vx = sin_t;
                vy = -cos_t;
                ang = HALF_PI_ANG;
            end else begin
                vx = -sin_t;
                vy = cos_t;
                ang = -HALF_PI_ANG;
            end
        end else begin
            vx = cos_t;
            vy = sin_t;
            ang = 0;
        end
        for (int i = 0; i < NSTEP; i++) begin
            if (vy > 0) begin
                nx = vx + (vy >>> i);
                vy = vy - (vx >>> i);
                ang = ang + angle_step[i];
            end else begin
                nx = vx - (vy >>> i);
                vy = vy + (vx >>> i);
                ang = ang - angle_step[i];
            end
            vx = nx;
        end
        rounded = (ang + 32768) >>> 16;
        if (rounded > 32768)
            rounded = 32768;
        if (rounded < -32768)
            rounded = -32768;
        return rounded[OUT_W-1:0];
    endfunction

    // Offer one quaternion from a falling edge; returns at the falling edge
    // after the transaction, with valid still high. Idle cycles go first.
    task automatic send_quat(
        input logic signed [Q_W-1:0]   w,
        input logic signed [Q_W-1:0]   x,
        input logic signed [Q_W-1:0]   y,
        input logic signed [Q_W-1:0]   z,
        input logic                    known,
        input logic signed [OUT_W-1:0] yaw
    );
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_quat_w = w;
        i_quat_x = x;
        i_quat_y = y;
        i_quat_z = z;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        yaw_due.push_back(known ? yaw : predict_yaw(w, x, y, z));
        @(negedge i_clk);
    endtask

    // Lower valid and hold off until every owed yaw has come back.
    task automatic drain_results;
        i_valid = 1'b0;
        while (yaw_due.size() != 0)
            @(negedge i_clk);
    endtask

    // Receiver back-pressure, redrawn each cycle.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Result check against the oldest owed yaw.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (yaw_due.size() == 0) begin
                $error("yaw_angle: result %0d with nothing outstanding", o_yaw_angle);
                err_count++;
            end else begin
                if (o_yaw_angle !== yaw_due[0]) begin
                    $error("yaw_angle mismatch: expected %0d, actual %0d",
                           yaw_due[0], o_yaw_angle);
                    err_count++;
                end
                void'(yaw_due.pop_front());
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        automatic int unsigned idle_plan  [N_PHASES] = '{0, 51, 0, 9};
        automatic int unsigned stall_plan [N_PHASES] = '{0, 0, 51, 9};
        logic signed [Q_W-1:0] qw, qx, qy, qz;
        real  theta, amp;
        int   pick;
        automatic logic [Q_W-1:0] corner [5] =
            '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_quat_w     = '0;
        i_quat_x     = '0;
        i_quat_y     = '0;
        i_quat_z     = '0;
        i_ready      = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        err_count    = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table, flat out
        for (int r = 0; r < N_ROWS; r++) begin
            send_quat(quat_table[r].w, quat_table[r].x, quat_table[r].y, quat_table[r].z,
                      quat_table[r].known, quat_table[r].yaw);
        end
        // sender waits for the pipe to empty before the random part
        drain_results();

        for (int p = 0; p < N_PHASES; p++) begin
            tx_idle_pct  = idle_plan[p];
            rx_stall_pct = stall_plan[p];
            for (int n = 0; n < N_RANDOM / N_PHASES; n++) begin
                pick = int'($urandom_range(0, 9));
                if (pick < 5) begin
                    // quaternion mostly about z with random scale, so the yaw sweeps the full circle
                    theta = ($urandom_range(0, 65535) / 65536.0 - 0.5) * 6.283185307179586;
                    amp   = $urandom_range(16000, 32767);
                    qw = Q_W'($rtoi(amp * $cos(theta / 2.0)));
                    qz = Q_W'($rtoi(amp * $sin(theta / 2.0)));
                    qx = Q_W'(int'($urandom_range(0, 4000)) - 2000);
                    qy = Q_W'(int'($urandom_range(0, 4000)) - 2000);
                    if ($urandom_range(0, 1)) begin
                        qw = -qw;
                        qx = -qx;
                        qy = -qy;
                        qz = -qz;
                    end
                end else if (pick < 8) begin
                    // raw bit patterns, unnormalised
                    qw = Q_W'($urandom);
                    qx = Q_W'($urandom);
                    qy = Q_W'($urandom);
                    qz = Q_W'($urandom);
                end else if (pick == 8) begin
                    // sine term forced to zero: one factor of each product cleared
                    qw = Q_W'($urandom);
                    qx = Q_W'($urandom);
                    qy = Q_W'($urandom);
                    qz = Q_W'($urandom);
                    if ($urandom_range(0, 1))
                        qw = '0;
                    else
                        qz = '0;
                    if ($urandom_range(0, 1))
                        qx = '0;
                    else
                        qy = '0;
                end else begin
                    qw = corner[$urandom_range(0, 4)];
                    qx = corner[$urandom_range(0, 4)];
                    qy = corner[$urandom_range(0, 4)];
                    qz = corner[$urandom_range(0, 4)];
                end
                send_quat(qw, qx, qy, qz, 1'b0, '0);
            end
            drain_results();
        end

        // let anything stray fall out of the pipeline
        repeat (4 * NSTEP + 20) @(posedge i_clk);

        if (err_count == 0 && yaw_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
